FILE: src/oaht_pkg.sv
// Shared constants, types and the color hash of the open-addressed hash table.
`default_nettype none

package oaht_pkg;

  localparam int unsigned DEPTH  = 256;
  localparam int unsigned SLOT_W = $clog2(DEPTH);
  localparam int unsigned SIZE_W = $clog2(DEPTH + 1);
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned VAL_W  = 16;
  localparam int unsigned HASH_W = 13;
  localparam int unsigned CFG_W  = 9;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned OUTS_W = 8;

  localparam logic [CFG_W-1:0] TABLE_SIZE_RST = 9'd256;
  localparam logic [7:0]       PROBE_STEP_RST = 8'd1;

  typedef enum logic [0:0] {
    CFG_TABLE_SIZE = 1'b0,
    CFG_PROBE_STEP = 1'b1
  } cfg_idx_e;

  typedef enum logic [STAT_W-1:0] {
    ST_HIT      = 3'd0,
    ST_MISS     = 3'd1,
    ST_INSERTED = 3'd2,
    ST_PRESENT  = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_HASH  = 2'd1,
    S_PROBE = 2'd2,
    S_DONE  = 2'd3
  } state_e;

  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [KEY_W-1:0]  wr_key;
    logic [VAL_W-1:0]  wr_value;
  } mem_req_t;

  typedef struct packed {
    logic             used;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } mem_rsp_t;

  // 13*red + 7*green + 3*blue, alpha ignored
  function automatic logic [HASH_W-1:0] hash_sum(input logic [KEY_W-1:0] key);
    logic [HASH_W-1:0] r;
    logic [HASH_W-1:0] g;
    logic [HASH_W-1:0] b;
    r = HASH_W'(key[31:24]);
    g = HASH_W'(key[23:16]);
    b = HASH_W'(key[15:8]);
    return (r * HASH_W'(13)) + (g * HASH_W'(7)) + (b * HASH_W'(3));
  endfunction

endpackage

`default_nettype wire

FILE: src/oaht_rem.sv
// Bit-serial restoring remainder unit: dividend modulo the active table size.
`default_nettype none

module oaht_rem (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [oaht_pkg::HASH_W-1:0]  dividend_i,
  input  wire logic [oaht_pkg::SIZE_W-1:0]  divisor_i,
  output logic                              done_o,
  output logic [oaht_pkg::SLOT_W-1:0]       rem_o
);

  localparam int unsigned CNT_W = $clog2(oaht_pkg::HASH_W);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic [oaht_pkg::HASH_W-1:0]   div_q, div_d;
  logic [oaht_pkg::SIZE_W-1:0]   rem_q, rem_d;
  logic [oaht_pkg::SIZE_W:0]     trial;
  logic [oaht_pkg::SIZE_W:0]     trial_sub;

  assign trial     = {rem_q, div_q[oaht_pkg::HASH_W-1]};
  assign trial_sub = trial - {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = CNT_W'(oaht_pkg::HASH_W - 1);
      div_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // one quotient bit per cycle, keep only the partial remainder
      rem_d = (trial >= {1'b0, divisor_i}) ? trial_sub[oaht_pkg::SIZE_W-1:0]
                                           : trial[oaht_pkg::SIZE_W-1:0];
      div_d = {div_q[oaht_pkg::HASH_W-2:0], 1'b0};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[oaht_pkg::SLOT_W-1:0];

endmodule

`default_nettype wire

FILE: src/oaht_store.sv
// Slot store: key/value memory with registered read and per-slot used marks.
`default_nettype none

module oaht_store (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire oaht_pkg::mem_req_t req_i,
  output oaht_pkg::mem_rsp_t      rsp_o
);

  localparam int unsigned ENTRY_W = oaht_pkg::KEY_W + oaht_pkg::VAL_W;

  logic [ENTRY_W-1:0]         mem_q [oaht_pkg::DEPTH];
  logic [ENTRY_W-1:0]         rd_data_q;
  logic [oaht_pkg::DEPTH-1:0] used_q;
  logic                       rd_used_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= {req_i.wr_key, req_i.wr_value};
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  // used marks clear at reset, so the table starts empty without a sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= '0;
      rd_used_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        used_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_used_q <= used_q[req_i.rd_addr];
      end
    end
  end

  assign rsp_o.used  = rd_used_q;
  assign rsp_o.key   = rd_data_q[ENTRY_W-1:oaht_pkg::VAL_W];
  assign rsp_o.value = rd_data_q[oaht_pkg::VAL_W-1:0];

endmodule

`default_nettype wire

FILE: src/open_addressed_hash_table_top.sv
// Top level of the open-addressed hash table: control sequencer and result register.
//
// Key/value table of 256 slots addressed by a 32-bit color key (red, green,
// blue, alpha). Opcode 0 looks a key up, opcode 1 inserts it with new_value.
// The home slot is (13*red + 7*green + 3*blue) mod table_size, and each failed
// probe advances by probe_step mod table_size, for at most table_size probes.
// An item runs through these steps, probing 1 up to table_size slots: it is
// accepted, the bit-serial remainder units reduce the hash and the probe step
// modulo the table size, the read of the home slot is issued, the slots are
// probed at one probe per cycle through the single read port of the slot
// memory, and the result is handed to the output register.
// One item is worked on at a time; a finished result waits in the output
// register while the next item is accepted. The used marks clear at reset,
// so the table is ready immediately; there is no clearing pass. Write
// table_size and probe_step only while the block is idle; a table_size of 0
// acts as 1 and one above 256 acts as 256. Slots beyond a reduced size keep
// their contents.
`default_nettype none

module open_addressed_hash_table_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input items
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          opcode_i,
  input  wire logic [oaht_pkg::KEY_W-1:0]    key_i,
  input  wire logic [oaht_pkg::VAL_W-1:0]    new_value_i,
  // result items
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [oaht_pkg::STAT_W-1:0]        status_o,
  output logic [oaht_pkg::VAL_W-1:0]         found_value_o,
  output logic [oaht_pkg::OUTS_W-1:0]        slot_index_o,
  // configuration writes
  input  wire logic                          cfg_we_i,
  input  wire logic [0:0]                    cfg_idx_i,
  input  wire logic [oaht_pkg::CFG_W-1:0]    cfg_data_i
);

  oaht_pkg::state_e                state_q, state_d;

  // configuration
  logic [oaht_pkg::CFG_W-1:0]      table_size_q;
  logic [7:0]                      probe_step_q;
  logic [oaht_pkg::SIZE_W-1:0]     size_n;

  // current item
  logic                            op_q;
  logic [oaht_pkg::KEY_W-1:0]      key_q;
  logic [oaht_pkg::VAL_W-1:0]      val_q;
  logic [oaht_pkg::SLOT_W-1:0]     step_q;
  logic [oaht_pkg::SLOT_W-1:0]     idx_q, idx_d;
  logic [oaht_pkg::SIZE_W-1:0]     tries_q, tries_d;

  // staged result and output register
  oaht_pkg::status_e               res_status_q, res_status_d;
  logic [oaht_pkg::VAL_W-1:0]      res_value_q, res_value_d;
  logic [oaht_pkg::SLOT_W-1:0]     res_slot_q, res_slot_d;
  logic                            out_valid_q;
  oaht_pkg::status_e               out_status_q;
  logic [oaht_pkg::VAL_W-1:0]      out_value_q;
  logic [oaht_pkg::SLOT_W-1:0]     out_slot_q;

  // remainder units and slot store
  logic                            rem_start;
  logic                            home_done;
  logic                            step_done;
  logic [oaht_pkg::SLOT_W-1:0]     home_slot;
  logic [oaht_pkg::SLOT_W-1:0]     step_rem;
  oaht_pkg::mem_req_t              mem_req;
  oaht_pkg::mem_rsp_t              mem_rsp;

  // probe evaluation
  logic                            accept;
  logic                            load_out;
  logic                            slot_free;
  logic                            key_match;
  logic                            hit;
  logic                            ins;
  logic                            present;
  logic                            term;
  logic                            last;
  logic [oaht_pkg::SIZE_W-1:0]     idx_sum;
  logic [oaht_pkg::SIZE_W-1:0]     idx_wrap;
  logic [oaht_pkg::SLOT_W-1:0]     idx_next;
  logic [oaht_pkg::SIZE_W-1:0]     tries_inc;

  // clamp the table size into 1..DEPTH
  always_comb begin
    if (table_size_q == '0) begin
      size_n = oaht_pkg::SIZE_W'(1);
    end else if (oaht_pkg::SIZE_W'(table_size_q) > oaht_pkg::SIZE_W'(oaht_pkg::DEPTH)) begin
      size_n = oaht_pkg::SIZE_W'(oaht_pkg::DEPTH);
    end else begin
      size_n = oaht_pkg::SIZE_W'(table_size_q);
    end
  end

  assign accept   = in_valid_i && in_ready_o;
  assign load_out = (state_q == oaht_pkg::S_DONE) && (!out_valid_q || out_ready_i);

  oaht_rem u_home_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (oaht_pkg::hash_sum(key_i)),
    .divisor_i  (size_n),
    .done_o     (home_done),
    .rem_o      (home_slot)
  );

  oaht_rem u_step_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (oaht_pkg::HASH_W'(probe_step_q)),
    .divisor_i  (size_n),
    .done_o     (step_done),
    .rem_o      (step_rem)
  );

  oaht_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mem_req),
    .rsp_o  (mem_rsp)
  );

  // The memory answers for idx_q in every probe cycle. An insert takes a
  // slot that is unused or holds the all-zero key; the key compare only
  // matters once the used mark says the entry was written.
  assign slot_free = !mem_rsp.used || (mem_rsp.key == '0);
  assign key_match = mem_rsp.key == key_q;
  assign hit       = !op_q && mem_rsp.used && key_match;
  assign ins       = op_q && slot_free;
  assign present   = op_q && !slot_free && key_match;
  assign term      = hit || ins || present;
  assign tries_inc = tries_q + oaht_pkg::SIZE_W'(1);
  assign last      = tries_inc == size_n;

  // both operands stay below the size, so one conditional subtract wraps
  assign idx_sum  = oaht_pkg::SIZE_W'(idx_q) + oaht_pkg::SIZE_W'(step_q);
  assign idx_wrap = (idx_sum >= size_n) ? (idx_sum - size_n) : idx_sum;
  assign idx_next = idx_wrap[oaht_pkg::SLOT_W-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      oaht_pkg::S_IDLE: begin
        if (accept) begin
          state_d = oaht_pkg::S_HASH;
        end
      end
      oaht_pkg::S_HASH: begin
        if (home_done && step_done) begin
          state_d = oaht_pkg::S_PROBE;
        end
      end
      oaht_pkg::S_PROBE: begin
        if (term || last) begin
          state_d = oaht_pkg::S_DONE;
        end
      end
      oaht_pkg::S_DONE: begin
        if (load_out) begin
          state_d = oaht_pkg::S_IDLE;
        end
      end
      default: state_d = oaht_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready_o       = 1'b0;
    rem_start        = 1'b0;
    mem_req          = '0;
    mem_req.wr_key   = key_q;
    mem_req.wr_value = val_q;
    mem_req.wr_addr  = idx_q;
    idx_d            = idx_q;
    tries_d          = tries_q;
    res_status_d     = res_status_q;
    res_value_d      = res_value_q;
    res_slot_d       = res_slot_q;
    unique case (state_q)
      oaht_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        rem_start  = accept;
      end
      oaht_pkg::S_HASH: begin
        // issue the read of the home slot as soon as it is known
        if (home_done && step_done) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = home_slot;
          idx_d           = home_slot;
          tries_d         = '0;
        end
      end
      oaht_pkg::S_PROBE: begin
        if (term) begin
          mem_req.wr_en = ins;
          res_status_d  = hit ? oaht_pkg::ST_HIT :
                          ins ? oaht_pkg::ST_INSERTED : oaht_pkg::ST_PRESENT;
          res_value_d   = hit ? mem_rsp.value : '0;
          res_slot_d    = idx_q;
        end else if (last) begin
          res_status_d = op_q ? oaht_pkg::ST_FULL : oaht_pkg::ST_MISS;
          res_value_d  = '0;
          res_slot_d   = '0;
        end else begin
          // advance and read the next slot in the same cycle
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = idx_next;
          idx_d           = idx_next;
          tries_d         = tries_inc;
        end
      end
      oaht_pkg::S_DONE: begin
        in_ready_o = 1'b0;
      end
      default: in_ready_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= oaht_pkg::S_IDLE;
      table_size_q <= oaht_pkg::TABLE_SIZE_RST;
      probe_step_q <= oaht_pkg::PROBE_STEP_RST;
      out_valid_q  <= 1'b0;
      tries_q      <= '0;
    end else begin
      state_q <= state_d;
      tries_q <= tries_d;
      if (cfg_we_i) begin
        unique case (oaht_pkg::cfg_idx_e'(cfg_idx_i))
          oaht_pkg::CFG_TABLE_SIZE: table_size_q <= cfg_data_i;
          oaht_pkg::CFG_PROBE_STEP: probe_step_q <= cfg_data_i[7:0];
          default:                  table_size_q <= table_size_q;
        endcase
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= opcode_i;
      key_q <= key_i;
      val_q <= new_value_i;
    end
    if ((state_q == oaht_pkg::S_HASH) && home_done && step_done) begin
      step_q <= step_rem;
    end
    idx_q        <= idx_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    res_slot_q   <= res_slot_d;
    if (load_out) begin
      out_status_q <= res_status_q;
      out_value_q  <= res_value_q;
      out_slot_q   <= res_slot_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign found_value_o = out_value_q;
  assign slot_index_o  = oaht_pkg::OUTS_W'(out_slot_q);

  // writes to the slot store happen only on a successful insert probe
  a_write_only_on_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.wr_en |-> (state_q == oaht_pkg::S_PROBE) && op_q && term)
    else $error("slot write outside an insert probe");

  // the probed slot and the probe count stay inside the active table
  a_probe_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == oaht_pkg::S_PROBE) |->
      (oaht_pkg::SIZE_W'(idx_q) < size_n) && (tries_q < size_n))
    else $error("probe outside the active table");

  // the reduced home slot must be below the table size
  a_home_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == oaht_pkg::S_HASH) && home_done) |->
      (oaht_pkg::SIZE_W'(home_slot) < size_n))
    else $error("home slot not reduced below table size");

  // misses and full tables report zero value and slot
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ((status_o == oaht_pkg::ST_MISS) || (status_o == oaht_pkg::ST_FULL))) |->
      (found_value_o == '0) && (slot_index_o == '0))
    else $error("miss or full result with nonzero fields");

endmodule

`default_nettype wire
